// ===== rtl/rar_pkg.sv =====
// Package: shared constants, codes and controller/datapath interface types.
`timescale 1ns / 1ps
package rar_pkg;

   localparam int OPERAND_WIDTH_DEF = 16;

   localparam logic [1:0] ACT_ADD = 2'd0;
   localparam logic [1:0] ACT_SUB = 2'd1;
   localparam logic [1:0] ACT_MUL = 2'd2;
   localparam logic [1:0] ACT_DIV = 2'd3;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD_A,   // capture request, working fraction = left operand
      CMD_PREP,     // seed gcd from working fraction
      CMD_GCD,      // one binary gcd step
      CMD_DIV_INIT, // seed both divider lanes with gcd as divisor
      CMD_DIV_STEP, // one restoring step on both lanes
      CMD_DIV_END,  // working fraction = signed quotients
      CMD_SAVE_A,   // a = working, working = right operand
      CMD_SAVE_B,   // b = working
      CMD_MUL0,
      CMD_MUL1,
      CMD_MUL2,
      CMD_FORM,     // combine products into working fraction
      CMD_TAKE_A    // divide by zero: result = reduced a
   } cmd_type;

   typedef struct packed {
      logic w_zero;
      logic gcd_done;
      logic div_last;
      logic div_zero;
   } status_type;

endpackage

// ===== rtl/rar_ctrl.sv =====
// Controller: sequences reduction of both operands, products and result reduction.
`timescale 1ns / 1ps
module rar_ctrl
   import rar_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   output logic       rsp_valid,
   output cmd_type    cmd,
   input  status_type status
);

   typedef enum logic [10:0] {
      S_IDLE = 11'b00000000001,
      S_PREP = 11'b00000000010,
      S_GCD  = 11'b00000000100,
      S_DIV  = 11'b00000001000,
      S_DEND = 11'b00000010000,
      S_WB   = 11'b00000100000,
      S_MUL0 = 11'b00001000000,
      S_MUL1 = 11'b00010000000,
      S_MUL2 = 11'b00100000000,
      S_FORM = 11'b01000000000,
      S_OUT  = 11'b10000000000
   } state_type;

   typedef enum logic [2:0] {
      PH_A   = 3'b001,
      PH_B   = 3'b010,
      PH_RES = 3'b100
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cmd      = CMD_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd      = CMD_LOAD_A;
               phase_in = PH_A;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            if (status.w_zero) begin
               state_in = S_WB;
            end else begin
               cmd      = CMD_PREP;
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            if (status.gcd_done) begin
               cmd      = CMD_DIV_INIT;
               state_in = S_DIV;
            end else begin
               cmd = CMD_GCD;
            end
         end
         S_DIV: begin
            cmd = CMD_DIV_STEP;
            if (status.div_last) state_in = S_DEND;
         end
         S_DEND: begin
            cmd      = CMD_DIV_END;
            state_in = S_WB;
         end
         S_WB: begin
            unique case (phase_ff)
               PH_A: begin
                  cmd      = CMD_SAVE_A;
                  phase_in = PH_B;
                  state_in = S_PREP;
               end
               PH_B: begin
                  // working fraction is reduced b here
                  if (status.div_zero) begin
                     cmd      = CMD_TAKE_A;
                     state_in = S_OUT;
                  end else begin
                     cmd      = CMD_SAVE_B;
                     state_in = S_MUL0;
                  end
               end
               default: state_in = S_OUT;
            endcase
         end
         S_MUL0: begin
            cmd      = CMD_MUL0;
            state_in = S_MUL1;
         end
         S_MUL1: begin
            cmd      = CMD_MUL1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd      = CMD_MUL2;
            state_in = S_FORM;
         end
         S_FORM: begin
            cmd      = CMD_FORM;
            phase_in = PH_RES;
            state_in = S_PREP;
         end
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_A;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

endmodule

// ===== rtl/rar_dp.sv =====
// Datapath: operand registers, multiplier, binary gcd and two-lane divider.
`timescale 1ns / 1ps
module rar_dp
   import rar_pkg::*;
#(
   parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
   input  logic                            clock,
   input  cmd_type                         cmd,
   output status_type                      status,
   input  logic [1:0]                      req_action,
   input  logic signed [OPERAND_WIDTH-1:0] req_a_num,
   input  logic signed [OPERAND_WIDTH-1:0] req_a_den,
   input  logic signed [OPERAND_WIDTH-1:0] req_b_num,
   input  logic signed [OPERAND_WIDTH-1:0] req_b_den,
   output logic signed [2*OPERAND_WIDTH:0] rsp_res_num,
   output logic signed [2*OPERAND_WIDTH-1:0] rsp_res_den,
   output logic                            rsp_div_zero
);

   localparam int OW = OPERAND_WIDTH;
   localparam int NW = 2 * OW + 1;
   localparam int MW = 2 * OW;
   localparam int CW = $clog2(MW);
   localparam int KW = $clog2(MW + 1);

   logic [1:0]           act_ff, act_in;
   logic signed [OW-1:0] bn_raw_ff, bn_raw_in, bd_raw_ff, bd_raw_in;
   logic signed [OW-1:0] an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic signed [NW-1:0] wn_ff, wn_in, wd_ff, wd_in;
   logic signed [NW-1:0] t0_ff, t0_in, t1_ff, t1_in, t2_ff, t2_in;
   logic                 flag_ff, flag_in;
   logic [MW-1:0]        x_ff, x_in, y_ff, y_in, g_ff, g_in;
   logic [KW-1:0]        k_ff, k_in;
   logic [MW-1:0]        rn_ff, rn_in, rd_ff, rd_in, qn_ff, qn_in, qd_ff, qd_in;
   logic [CW-1:0]        cnt_ff, cnt_in;

   logic signed [OW-1:0]   mul_x, mul_y;
   logic signed [2*OW-1:0] prod;
   logic signed [NW-1:0]   wn_neg, wd_neg;
   logic [MW-1:0]          mag_n, mag_d, gcd_val;
   logic [MW:0]            sn, sd;
   logic                   ge_n, ge_d;
   logic [MW-1:0]          qn_nx, qd_nx;

   assign wn_neg = -wn_ff;
   assign wd_neg = -wd_ff;
   assign mag_n  = wn_ff[NW-1] ? wn_neg[MW-1:0] : wn_ff[MW-1:0];
   assign mag_d  = wd_ff[NW-1] ? wd_neg[MW-1:0] : wd_ff[MW-1:0];
   assign gcd_val = MW'((x_ff | y_ff) << k_ff);

   // restoring divider lanes share the divisor
   assign sn    = {rn_ff, qn_ff[MW-1]};
   assign sd    = {rd_ff, qd_ff[MW-1]};
   assign ge_n  = (sn >= {1'b0, g_ff});
   assign ge_d  = (sd >= {1'b0, g_ff});
   assign qn_nx = {qn_ff[MW-2:0], ge_n};
   assign qd_nx = {qd_ff[MW-2:0], ge_d};

   always_comb begin
      unique case (cmd)
         CMD_MUL0: begin
            mul_x = an_ff;
            mul_y = (act_ff == ACT_MUL) ? bn_ff : bd_ff;
         end
         CMD_MUL1: begin
            mul_x = bn_ff;
            mul_y = ad_ff;
         end
         default: begin
            mul_x = ad_ff;
            mul_y = (act_ff == ACT_DIV) ? bn_ff : bd_ff;
         end
      endcase
   end
   assign prod = mul_x * mul_y;

   always_comb begin
      act_in    = act_ff;
      bn_raw_in = bn_raw_ff;
      bd_raw_in = bd_raw_ff;
      an_in = an_ff;
      ad_in = ad_ff;
      bn_in = bn_ff;
      bd_in = bd_ff;
      wn_in = wn_ff;
      wd_in = wd_ff;
      t0_in = t0_ff;
      t1_in = t1_ff;
      t2_in = t2_ff;
      flag_in = flag_ff;
      x_in = x_ff;
      y_in = y_ff;
      g_in = g_ff;
      k_in = k_ff;
      rn_in = rn_ff;
      rd_in = rd_ff;
      qn_in = qn_ff;
      qd_in = qd_ff;
      cnt_in = cnt_ff;
      unique case (cmd)
         CMD_LOAD_A: begin
            act_in    = req_action;
            bn_raw_in = req_b_num;
            bd_raw_in = req_b_den;
            flag_in   = 1'b0;
            wn_in     = NW'(req_a_num);
            wd_in     = (req_a_den == '0) ? NW'(1) : NW'(req_a_den);
         end
         CMD_PREP: begin
            x_in = mag_n;
            y_in = mag_d;
            k_in = '0;
         end
         CMD_GCD: begin
            if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + KW'(1);
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (x_ff >= y_ff) begin
               x_in = (x_ff - y_ff) >> 1;
            end else begin
               y_in = (y_ff - x_ff) >> 1;
            end
         end
         CMD_DIV_INIT: begin
            g_in   = gcd_val;
            rn_in  = '0;
            rd_in  = '0;
            qn_in  = mag_n;
            qd_in  = mag_d;
            cnt_in = CW'(MW - 1);
         end
         CMD_DIV_STEP: begin
            rn_in  = ge_n ? MW'(sn - {1'b0, g_ff}) : sn[MW-1:0];
            rd_in  = ge_d ? MW'(sd - {1'b0, g_ff}) : sd[MW-1:0];
            qn_in  = qn_nx;
            qd_in  = qd_nx;
            cnt_in = cnt_ff - CW'(1);
         end
         CMD_DIV_END: begin
            wn_in = wn_ff[NW-1] ? -NW'({1'b0, qn_ff}) : NW'({1'b0, qn_ff});
            wd_in = wd_ff[NW-1] ? -NW'({1'b0, qd_ff}) : NW'({1'b0, qd_ff});
         end
         CMD_SAVE_A: begin
            an_in = wn_ff[OW-1:0];
            ad_in = wd_ff[OW-1:0];
            wn_in = NW'(bn_raw_ff);
            wd_in = (bd_raw_ff == '0) ? NW'(1) : NW'(bd_raw_ff);
         end
         CMD_SAVE_B: begin
            bn_in = wn_ff[OW-1:0];
            bd_in = wd_ff[OW-1:0];
         end
         CMD_MUL0: t0_in = NW'(prod);
         CMD_MUL1: t1_in = NW'(prod);
         CMD_MUL2: t2_in = NW'(prod);
         CMD_FORM: begin
            unique case (act_ff)
               ACT_ADD: wn_in = t0_ff + t1_ff;
               ACT_SUB: wn_in = t0_ff - t1_ff;
               default: wn_in = t0_ff;
            endcase
            wd_in = t2_ff;
         end
         CMD_TAKE_A: begin
            wn_in   = NW'(an_ff);
            wd_in   = NW'(ad_ff);
            flag_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      bn_raw_ff <= bn_raw_in;
      bd_raw_ff <= bd_raw_in;
      an_ff <= an_in;
      ad_ff <= ad_in;
      bn_ff <= bn_in;
      bd_ff <= bd_in;
      wn_ff <= wn_in;
      wd_ff <= wd_in;
      t0_ff <= t0_in;
      t1_ff <= t1_in;
      t2_ff <= t2_in;
      flag_ff <= flag_in;
      x_ff <= x_in;
      y_ff <= y_in;
      g_ff <= g_in;
      k_ff <= k_in;
      rn_ff <= rn_in;
      rd_ff <= rd_in;
      qn_ff <= qn_in;
      qd_ff <= qd_in;
      cnt_ff <= cnt_in;
   end

   assign status.w_zero   = (wn_ff == '0);
   assign status.gcd_done = (x_ff == '0) || (y_ff == '0);
   assign status.div_last = (cnt_ff == '0);
   assign status.div_zero = (act_ff == ACT_DIV) && (wn_ff == '0);

   assign rsp_res_num  = wn_ff;
   assign rsp_res_den  = wd_ff[MW-1:0];
   assign rsp_div_zero = flag_ff;

endmodule

// ===== rtl/rational_arith_reduce.sv =====
// Top level: signed fraction add/sub/mul/div with gcd reduction.
// Sequence: each fraction reduction runs prep, binary gcd steps, divider init, the
// divider steps and the quotient write, or goes straight to write-back for a zero numerator;
// an item runs three reductions (two on divide by zero), MUL0, MUL1, MUL2, FORM and output.
// Throughput: one item at a time; busy stays high until the result strobe. No stalls.
// Reset (synchronous) returns the controller to idle; datapath registers are not reset.
`timescale 1ns / 1ps
module rational_arith_reduce
   import rar_pkg::*;
#(
   parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_action,
   input  logic signed [OPERAND_WIDTH-1:0]   req_a_num,
   input  logic signed [OPERAND_WIDTH-1:0]   req_a_den,
   input  logic signed [OPERAND_WIDTH-1:0]   req_b_num,
   input  logic signed [OPERAND_WIDTH-1:0]   req_b_den,
   output logic                              rsp_valid,
   output logic signed [2*OPERAND_WIDTH:0]   rsp_res_num,
   output logic signed [2*OPERAND_WIDTH-1:0] rsp_res_den,
   output logic                              rsp_div_zero
);

   cmd_type    cmd;
   status_type status;

   rar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   rar_dp #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_dp (
      .clock        (clock),
      .cmd          (cmd),
      .status       (status),
      .req_action   (req_action),
      .req_a_num    (req_a_num),
      .req_a_den    (req_a_den),
      .req_b_num    (req_b_num),
      .req_b_den    (req_b_den),
      .rsp_res_num  (rsp_res_num),
      .rsp_res_den  (rsp_res_den),
      .rsp_div_zero (rsp_div_zero)
   );

endmodule

// ===== dv/rational_arith_reduce_tb.sv =====
// Self-checking testbench for the rational_arith_reduce fraction arithmetic unit.
`timescale 1ns / 1ps
module rational_arith_reduce_tb
   import rar_pkg::*;
();

   localparam int W = OPERAND_WIDTH_DEF;
   localparam int CYCLE_LIMIT = 2000000;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [1:0]            req_action;
   logic signed [W-1:0]   req_a_num;
   logic signed [W-1:0]   req_a_den;
   logic signed [W-1:0]   req_b_num;
   logic signed [W-1:0]   req_b_den;
   logic                  rsp_valid;
   logic signed [2*W:0]   rsp_res_num;
   logic signed [2*W-1:0] rsp_res_den;
   logic                  rsp_div_zero;

   typedef struct packed {
      logic signed [2*W:0]   num;
      logic signed [2*W-1:0] den;
      logic                  dz;
   } fraction_result_type;

   fraction_result_type expected_fracs[$];
   int errors = 0;
   int cycles = 0;

   rational_arith_reduce dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_a_num(req_a_num), .req_a_den(req_a_den),
      .req_b_num(req_b_num), .req_b_den(req_b_den), .rsp_valid(rsp_valid),
      .rsp_res_num(rsp_res_num), .rsp_res_den(rsp_res_den),
      .rsp_div_zero(rsp_div_zero)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic longint gcd_mag(longint x, longint y);
      longint t;
      if (x < 0) x = -x;
      if (y < 0) y = -y;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   // zero den -> 1; zero num is left unreduced
   function automatic void reduce_frac(input longint n_in, input longint d_in,
                                       output longint n, output longint d);
      longint g;
      n = n_in;
      d = (d_in == 0) ? 1 : d_in;
      if (n != 0) begin
         g = gcd_mag(n, d);
         if (g > 1) begin
            n = n / g;
            d = d / g;
         end
      end
   endfunction

   function automatic fraction_result_type compute_fraction(
      logic [1:0] act, logic signed [W-1:0] an, logic signed [W-1:0] ad,
      logic signed [W-1:0] bn, logic signed [W-1:0] bd);
      fraction_result_type r;
      longint xn, xd, yn, yd, rn, rd;
      reduce_frac(an, ad, xn, xd);
      reduce_frac(bn, bd, yn, yd);
      r.dz = 1'b0;
      case (act)
         ACT_ADD: reduce_frac(xn * yd + yn * xd, xd * yd, rn, rd);
         ACT_SUB: reduce_frac(xn * yd - yn * xd, xd * yd, rn, rd);
         ACT_MUL: reduce_frac(xn * yn, xd * yd, rn, rd);
         default: begin
            if (yn != 0) reduce_frac(xn * yd, xd * yn, rn, rd);
            else begin
               rn = xn;
               rd = xd;
               r.dz = 1'b1;
            end
         end
      endcase
      r.num = rn[2*W:0];
      r.den = rd[2*W-1:0];
      return r;
   endfunction

   // all bits sampled at the edge; driving happens after via NBA
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid) begin
         if (expected_fracs.size() == 0) begin
            $error("unexpected result num=%0d den=%0d", rsp_res_num, rsp_res_den);
            errors = errors + 1;
         end else begin
            fraction_result_type e;
            e = expected_fracs.pop_front();
            if (rsp_res_num !== e.num) begin
               $error("res_num expected %0d actual %0d", e.num, rsp_res_num);
               errors = errors + 1;
            end
            if (rsp_res_den !== e.den) begin
               $error("res_den expected %0d actual %0d", e.den, rsp_res_den);
               errors = errors + 1;
            end
            if (rsp_div_zero !== e.dz) begin
               $error("div_zero expected %0d actual %0d", e.dz, rsp_div_zero);
               errors = errors + 1;
            end
         end
      end
   end

   initial begin
      @(posedge clock);
      wait (cycles >= CYCLE_LIMIT);
      $display("rational_arith_reduce verification failed");
      $finish;
   end

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 3);
      repeat (n) @(posedge clock);
   endtask

   task automatic send_fraction(input logic [1:0] act, input logic signed [W-1:0] an,
                                input logic signed [W-1:0] ad,
                                input logic signed [W-1:0] bn,
                                input logic signed [W-1:0] bd, input bit gaps);
      if (gaps) idle_gap();
      start      <= 1'b1;
      req_action <= act;
      req_a_num  <= an;
      req_a_den  <= ad;
      req_b_num  <= bn;
      req_b_den  <= bd;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_fracs.push_back(compute_fraction(act, an, ad, bn, bd));
      start <= 1'b0;
      // step past the transfer edge so the next item is driven at a later edge
      @(posedge clock);
   endtask

   function automatic logic signed [W-1:0] pick_operand();
      case ($urandom_range(0, 5))
         0: return logic'(W'($urandom_range(0, 2))) ? 16'sh7fff : 16'sh8000;
         1: return $urandom_range(0, 1) ? W'(0) : W'(-1);
         2: return W'($signed($urandom_range(0, 24)) - 12);
         3: return W'(($urandom_range(1, 60)) * (1 << $urandom_range(0, 8)));
         default: return W'($urandom);
      endcase
   endfunction

   task automatic drain();
      while (expected_fracs.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      logic [1:0] ops[4] = '{ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV};
      foreach (ops[i]) begin
         send_fraction(ops[i], 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 1'b0);
         send_fraction(ops[i], 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
         // zero numerator, zero den
         send_fraction(ops[i], 16'sd0, 16'sd5, 16'sd3, 16'sd0, 1'b0);
         // negative den, zero b
         send_fraction(ops[i], 16'sd6, -16'sd4, 16'sd0, -16'sd7, 1'b0);
         send_fraction(ops[i], -16'sd1, 16'sh7fff, 16'sh7fff, 16'sd1, 1'b0);
      end
      // divide by zero fraction
      send_fraction(ACT_DIV, 16'sd9, 16'sd12, 16'sd0, 16'sd0, 1'b0);
      // result zero over formed den
      send_fraction(ACT_SUB, 16'sd3, 16'sd4, 16'sd3, 16'sd4, 1'b0);
   endtask

   task automatic test_quiesce();
      send_fraction(ACT_MUL, 16'sd12, 16'sd18, -16'sd5, 16'sd10, 1'b1);
      drain();  // sender holds until every expectation is met
      send_fraction(ACT_DIV, 16'sd7, 16'sd0, 16'sd14, 16'sd3, 1'b1);
   endtask

   task automatic test_random(input int count);
      repeat (count)
         send_fraction(2'($urandom), pick_operand(), pick_operand(),
                       pick_operand(), pick_operand(), $urandom_range(0, 3) != 0);
   endtask

   initial begin
      reset      <= 1'b1;
      start      <= 1'b0;
      req_action <= ACT_ADD;
      req_a_num  <= '0;
      req_a_den  <= '0;
      req_b_num  <= '0;
      req_b_den  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_quiesce();
      test_random(300);
      test_random(300);
      drain();
      repeat (200) @(posedge clock);
      if (errors == 0 && expected_fracs.size() == 0)
         $display("rational_arith_reduce verification clean");
      else
         $display("rational_arith_reduce verification failed");
      $finish;
   end
endmodule
